// File: rtl/cpfa_pkg.sv
`default_nettype none
package cpfa_pkg;

    localparam int CW   = 24;  // coordinate / radius width
    localparam int BW   = 12;  // box size width
    localparam int DW   = 26;  // signed delta width
    localparam int MW   = 25;  // delta magnitude width
    localparam int D2W  = 48;  // squared distance kept for in-range pairs
    localparam int RW   = 26;  // signed local equilibrium radius
    localparam int NW   = 27;  // signed numerator / denominator
    localparam int SQW  = 27;  // square root remainder
    localparam int DVW  = 41;  // divider dividend / quotient
    localparam int DSW  = 25;  // divider divisor
    localparam int TW   = 39;  // saturated ratio term
    localparam int UW   = 17;  // unit vector component, Q1.16
    localparam int GW   = 24;  // scaled gain
    localparam int PW   = 64;  // force product
    localparam int FW   = 47;  // force magnitude, Q31.16
    localparam int AW   = 32;  // accumulator
    localparam int SW   = 50;  // accumulator sum before saturation
    localparam int CNTB = 6;   // iteration counter
    localparam int IW   = 3;   // register index

    localparam logic [TW-1:0]   T_SAT   = {1'b1, {(TW-1){1'b0}}};
    localparam logic [CNTB-1:0] SQ_LAST = CNTB'(CW - 1);
    localparam logic [CNTB-1:0] DV_LAST = CNTB'(DVW - 1);

    localparam logic [IW-1:0] REG_BOX_WIDTH  = 3'd0;
    localparam logic [IW-1:0] REG_BOX_HEIGHT = 3'd1;
    localparam logic [IW-1:0] REG_EQ_RADIUS  = 3'd2;
    localparam logic [IW-1:0] REG_MAX_RADIUS = 3'd3;
    localparam logic [IW-1:0] REG_REP_GAIN   = 3'd4;
    localparam logic [IW-1:0] REG_ADH_GAIN   = 3'd5;

    typedef struct packed {
        logic [BW-1:0] box_width;
        logic [BW-1:0] box_height;
        logic [CW-1:0] eq_radius;
        logic [CW-1:0] max_radius;
        logic [CW-1:0] repulsion_gain;
        logic [CW-1:0] adhesion_gain;
    } t_cfg;

    typedef struct packed {
        logic                 active;
        logic                 last;
        logic                 rep;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic [D2W-1:0]       d2;
        logic signed [RW-1:0] req;
        logic signed [NW-1:0] den;
    } t_pair;

endpackage
`default_nettype wire

// File: rtl/cell_pair_force_accumulator_top.sv
`default_nettype none
// Neighbour-pair force accumulator. A two-stage front end takes one pair word per
// cycle while o_stall is low, forms the wrapped dx/dy, the squared distance and the
// range class, and queues the pair (QUEUE_DEPTH entries). The back end works one
// queued pair at a time: a pair without a neighbour, out of range or with a zero
// denominator skips straight to the output step; an interacting pair runs through
// the bit-serial square root and the shared radix-2 divider (used three times).
// The sums are emitted as one word with force_x/force_y on the last pair and cleared.
module cell_pair_force_accumulator_top import cpfa_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [IW-1:0]        i_cfg_index,
    input  wire logic [CW-1:0]        i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [CW-1:0]        i_self_x,
    input  wire logic [CW-1:0]        i_self_y,
    input  wire logic signed [CW-1:0] i_self_radius_offset,
    input  wire logic [CW-1:0]        i_other_x,
    input  wire logic [CW-1:0]        i_other_y,
    input  wire logic                 i_other_exists,
    input  wire logic                 i_wrap_enable,
    input  wire logic                 i_last_pair,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic signed [AW-1:0]      o_force_x,
    output logic signed [AW-1:0]      o_force_y
);

    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    t_cfg            r_cfg;
    t_pair           push_pair, head;
    logic            push, pop, empty;
    logic [CNTW-1:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_width      <= BW'(256);
            r_cfg.box_height     <= BW'(256);
            r_cfg.eq_radius      <= CW'(4096);
            r_cfg.max_radius     <= CW'(5324);
            r_cfg.repulsion_gain <= CW'(65536);
            r_cfg.adhesion_gain  <= CW'(65536);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_BOX_WIDTH:  r_cfg.box_width      <= i_cfg_data[BW-1:0];
                REG_BOX_HEIGHT: r_cfg.box_height     <= i_cfg_data[BW-1:0];
                REG_EQ_RADIUS:  r_cfg.eq_radius      <= i_cfg_data;
                REG_MAX_RADIUS: r_cfg.max_radius     <= i_cfg_data;
                REG_REP_GAIN:   r_cfg.repulsion_gain <= i_cfg_data;
                REG_ADH_GAIN:   r_cfg.adhesion_gain  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cpfa_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_self_x             (i_self_x),
        .i_self_y             (i_self_y),
        .i_self_radius_offset (i_self_radius_offset),
        .i_other_x            (i_other_x),
        .i_other_y            (i_other_y),
        .i_other_exists       (i_other_exists),
        .i_wrap_enable        (i_wrap_enable),
        .i_last_pair          (i_last_pair),
        .i_q_count            (q_count),
        .o_push               (push),
        .o_pair               (push_pair)
    );

    cpfa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (push_pair),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_count (q_count)
    );

    cpfa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_head    (head),
        .i_empty   (empty),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_force_x (o_force_x),
        .o_force_y (o_force_y)
    );

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("queue popped while empty");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (q_count < CNTW'(QUEUE_DEPTH)))
        else $error("queue pushed while full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CNTW'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// File: rtl/cpfa_front.sv
`default_nettype none
module cpfa_front import cpfa_pkg::*; #(
    parameter int DEPTH = 4,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cfg                 i_cfg,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [CW-1:0]        i_self_x,
    input  wire logic [CW-1:0]        i_self_y,
    input  wire logic signed [CW-1:0] i_self_radius_offset,
    input  wire logic [CW-1:0]        i_other_x,
    input  wire logic [CW-1:0]        i_other_y,
    input  wire logic                 i_other_exists,
    input  wire logic                 i_wrap_enable,
    input  wire logic                 i_last_pair,
    input  wire logic [CNTW-1:0]      i_q_count,
    output logic                      o_push,
    output t_pair                     o_pair
);

    function automatic logic signed [DW-1:0] wrap_delta(
        input logic signed [DW-1:0] d,
        input logic [BW-1:0]        box,
        input logic                 en
    );
        logic signed [DW-1:0] half;
        logic signed [DW-1:0] full;
        half = $signed({3'b000, box, 11'b0});
        full = $signed({2'b00, box, 12'b0});
        if (en && (d < -half)) begin
            return d + full;
        end else if (en && (d > half)) begin
            return d - full;
        end
        return d;
    endfunction

    logic                 accept;
    logic signed [DW-1:0] raw_dx, raw_dy;
    logic signed [RW-1:0] req;

    logic                 r_s1_valid, r_s1_exists, r_s1_last;
    logic signed [DW-1:0] r_s1_dx, r_s1_dy;
    logic signed [RW-1:0] r_s1_req;

    logic                 r_s2_valid, r_s2_exists, r_s2_last;
    logic signed [DW-1:0] r_s2_dx, r_s2_dy;
    logic signed [RW-1:0] r_s2_req;
    logic signed [NW-1:0] r_s2_adh_den;
    logic [2*MW-1:0]      r_s2_sqx, r_s2_sqy;
    logic [D2W-1:0]       r_max_sq, r_eq_sq;

    logic signed [DW-1:0] neg_dx, neg_dy;
    logic [MW-1:0]        mag_x, mag_y;
    logic [2*MW-1:0]      sqx, sqy;
    logic signed [NW-1:0] adh_den;
    logic [2*MW:0]        d2;
    logic                 in_rng, rep;

    assign o_stall = ({1'b0, i_q_count} + (CNTW+1)'(r_s1_valid) + (CNTW+1)'(r_s2_valid))
                     >= (CNTW+1)'(DEPTH);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        raw_dx = $signed({2'b00, i_self_x}) - $signed({2'b00, i_other_x});
        raw_dy = $signed({2'b00, i_self_y}) - $signed({2'b00, i_other_y});
        req    = $signed({2'b00, i_cfg.eq_radius})
                 + $signed({{2{i_self_radius_offset[CW-1]}}, i_self_radius_offset});
    end

    always_comb begin
        neg_dx  = -r_s1_dx;
        neg_dy  = -r_s1_dy;
        mag_x   = r_s1_dx[DW-1] ? neg_dx[MW-1:0] : r_s1_dx[MW-1:0];
        mag_y   = r_s1_dy[DW-1] ? neg_dy[MW-1:0] : r_s1_dy[MW-1:0];
        sqx     = mag_x * mag_x;
        sqy     = mag_y * mag_y;
        adh_den = $signed({3'b000, i_cfg.max_radius}) - $signed({r_s1_req[RW-1], r_s1_req});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_max_sq     <= i_cfg.max_radius * i_cfg.max_radius;
        r_eq_sq      <= i_cfg.eq_radius * i_cfg.eq_radius;
        r_s1_exists  <= i_other_exists;
        r_s1_last    <= i_last_pair;
        r_s1_dx      <= wrap_delta(raw_dx, i_cfg.box_width, i_wrap_enable);
        r_s1_dy      <= wrap_delta(raw_dy, i_cfg.box_height, i_wrap_enable);
        r_s1_req     <= req;
        r_s2_exists  <= r_s1_exists;
        r_s2_last    <= r_s1_last;
        r_s2_dx      <= r_s1_dx;
        r_s2_dy      <= r_s1_dy;
        r_s2_req     <= r_s1_req;
        r_s2_adh_den <= adh_den;
        r_s2_sqx     <= sqx;
        r_s2_sqy     <= sqy;
    end

    always_comb begin
        d2            = {1'b0, r_s2_sqx} + {1'b0, r_s2_sqy};
        in_rng        = (d2 != '0) && (d2 < {3'b000, r_max_sq});
        rep           = d2 < {3'b000, r_eq_sq};
        o_push        = r_s2_valid;
        o_pair.active = r_s2_exists && in_rng;
        o_pair.last   = r_s2_last;
        o_pair.rep    = rep;
        o_pair.dx     = r_s2_dx;
        o_pair.dy     = r_s2_dy;
        o_pair.d2     = d2[D2W-1:0];
        o_pair.req    = r_s2_req;
        o_pair.den    = rep ? $signed({r_s2_req[RW-1], r_s2_req}) : r_s2_adh_den;
    end

endmodule
`default_nettype wire

// File: rtl/cpfa_queue.sv
`default_nettype none
module cpfa_queue import cpfa_pkg::*; #(
    parameter int DEPTH = 4,
    localparam int AWD  = $clog2(DEPTH),
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_pair       i_pair,
    input  wire logic        i_pop,
    output t_pair            o_head,
    output logic             o_empty,
    output logic [CNTW-1:0]  o_count
);

    t_pair            r_mem [DEPTH];
    logic [AWD-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [CNTW-1:0]  r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AWD'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AWD'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pair;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule
`default_nettype wire

// File: rtl/cpfa_back.sv
`default_nettype none
module cpfa_back import cpfa_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cfg            i_cfg,
    input  wire t_pair           i_head,
    input  wire logic            i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic signed [AW-1:0] o_force_x,
    output logic signed [AW-1:0] o_force_y
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQRT  = 4'd1;
    localparam logic [3:0] S_TLOAD = 4'd2;
    localparam logic [3:0] S_TDIV  = 4'd3;
    localparam logic [3:0] S_ULOAD = 4'd4;
    localparam logic [3:0] S_UDIV  = 4'd5;
    localparam logic [3:0] S_GMUL  = 4'd6;
    localparam logic [3:0] S_MLO   = 4'd7;
    localparam logic [3:0] S_MHI   = 4'd8;
    localparam logic [3:0] S_ACC   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]           r_state, n_state;
    t_pair                r_e, n_e;
    logic [CNTB-1:0]      r_cnt, n_cnt;
    logic [D2W-1:0]       r_sq_v, n_sq_v;
    logic [SQW-1:0]       r_sq_rem, n_sq_rem;
    logic [CW-1:0]        r_root, n_root;
    logic [DVW-1:0]       r_dv_q, n_dv_q;
    logic [DSW-1:0]       r_dv_rem, n_dv_rem, r_dv_den, n_dv_den;
    logic                 r_num_neg, n_num_neg;
    logic [TW-1:0]        r_t, n_t;
    logic [UW-1:0]        r_u, n_u;
    logic [GW-1:0]        r_g, n_g;
    logic [PW-1:0]        r_prod, n_prod;
    logic                 r_axis, n_axis;
    logic signed [AW-1:0] r_sum_x, n_sum_x, r_sum_y, n_sum_y;
    logic                 r_out_valid, n_out_valid;
    logic signed [AW-1:0] r_fx, n_fx, r_fy, n_fy;

    logic [SQW-1:0]       sq_sh, sq_trial;
    logic                 sq_ge;
    logic [DSW:0]         dv_sh, dv_diff;
    logic                 dv_ge;
    logic signed [NW-1:0] num, num_neg, den_neg;
    logic [NW-1:0]        num_mag, den_mag;
    logic signed [DW-1:0] delta, delta_neg;
    logic [DW-1:0]        delta_mag;
    logic [GW-1:0]        gain;
    logic [GW+UW-1:0]     g_prod;
    logic [GW+19:0]       lo_prod;
    logic [GW+18:0]       hi_prod;
    logic [FW-1:0]        f;
    logic signed [SW-1:0] f_ext, sf, acc;
    logic signed [AW-1:0] sum_sel, acc_sat;
    logic                 f_neg;

    always_comb begin
        sq_sh     = {r_sq_rem[SQW-3:0], r_sq_v[D2W-1 -: 2]};
        sq_trial  = {1'b0, r_root, 2'b01};
        sq_ge     = sq_sh >= sq_trial;
        dv_sh     = {r_dv_rem, r_dv_q[DVW-1]};
        dv_diff   = dv_sh - {1'b0, r_dv_den};
        dv_ge     = dv_sh >= {1'b0, r_dv_den};
        num       = $signed({r_e.req[RW-1], r_e.req}) - $signed({3'b000, r_root});
        num_neg   = -num;
        num_mag   = num[NW-1] ? num_neg : num;
        den_neg   = -r_e.den;
        den_mag   = r_e.den[NW-1] ? den_neg : r_e.den;
        delta     = r_axis ? r_e.dy : r_e.dx;
        delta_neg = -delta;
        delta_mag = delta[DW-1] ? delta_neg : delta;
        gain      = r_e.rep ? i_cfg.repulsion_gain : i_cfg.adhesion_gain;
        g_prod    = gain * r_u;
        lo_prod   = r_g * r_t[19:0];
        hi_prod   = r_g * r_t[TW-1:20];
        f         = r_prod[FW+15:16];
        f_ext     = $signed({3'b000, f});
        f_neg     = delta[DW-1] ^ r_num_neg ^ r_e.den[NW-1];
        sf        = f_neg ? -f_ext : f_ext;
        sum_sel   = r_axis ? r_sum_y : r_sum_x;
        acc       = $signed({{(SW-AW){sum_sel[AW-1]}}, sum_sel}) + sf;
        if ((&acc[SW-1:AW-1]) || !(|acc[SW-1:AW-1])) begin
            acc_sat = acc[AW-1:0];
        end else begin
            acc_sat = acc[SW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_e         = r_e;
        n_cnt       = r_cnt;
        n_sq_v      = r_sq_v;
        n_sq_rem    = r_sq_rem;
        n_root      = r_root;
        n_dv_q      = r_dv_q;
        n_dv_rem    = r_dv_rem;
        n_dv_den    = r_dv_den;
        n_num_neg   = r_num_neg;
        n_t         = r_t;
        n_u         = r_u;
        n_g         = r_g;
        n_prod      = r_prod;
        n_axis      = r_axis;
        n_sum_x     = r_sum_x;
        n_sum_y     = r_sum_y;
        n_fx        = r_fx;
        n_fy        = r_fy;
        n_out_valid = r_out_valid && i_stall;
        o_pop       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    n_e      = i_head;
                    n_sq_v   = i_head.d2;
                    n_sq_rem = '0;
                    n_root   = '0;
                    n_cnt    = SQ_LAST;
                    n_state  = (i_head.active && (i_head.den != '0)) ? S_SQRT : S_DONE;
                end
            end
            S_SQRT: begin
                n_sq_v   = {r_sq_v[D2W-3:0], 2'b00};
                n_sq_rem = sq_ge ? sq_sh - sq_trial : sq_sh;
                n_root   = {r_root[CW-2:0], sq_ge};
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_TLOAD;
                end
            end
            S_TLOAD: begin
                n_num_neg = num[NW-1];
                n_dv_q    = {num_mag[DSW-1:0], 16'b0};
                n_dv_rem  = '0;
                n_dv_den  = den_mag[DSW-1:0];
                n_cnt     = DV_LAST;
                n_state   = S_TDIV;
            end
            S_TDIV, S_UDIV: begin
                n_dv_q   = {r_dv_q[DVW-2:0], dv_ge};
                n_dv_rem = dv_ge ? dv_diff[DSW-1:0] : dv_sh[DSW-1:0];
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    if (r_state == S_TDIV) begin
                        n_t     = (n_dv_q > {2'b00, T_SAT}) ? T_SAT : n_dv_q[TW-1:0];
                        n_axis  = 1'b0;
                        n_state = S_ULOAD;
                    end else begin
                        n_u     = n_dv_q[UW-1:0];
                        n_state = S_GMUL;
                    end
                end
            end
            S_ULOAD: begin
                n_dv_q   = {delta_mag[DSW-1:0], 16'b0};
                n_dv_rem = '0;
                n_dv_den = {1'b0, r_root};
                n_cnt    = DV_LAST;
                n_state  = S_UDIV;
            end
            S_GMUL: begin
                n_g     = g_prod[GW+15:16];
                n_state = S_MLO;
            end
            S_MLO: begin
                n_prod  = {{(PW-GW-20){1'b0}}, lo_prod};
                n_state = S_MHI;
            end
            S_MHI: begin
                n_prod  = r_prod + {1'b0, hi_prod, 20'b0};
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_axis) begin
                    n_sum_y = acc_sat;
                    n_state = S_DONE;
                end else begin
                    n_sum_x = acc_sat;
                    n_axis  = 1'b1;
                    n_state = S_ULOAD;
                end
            end
            S_DONE: begin
                if (!r_e.last) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_fx        = r_sum_x;
                    n_fy        = r_sum_y;
                    n_sum_x     = '0;
                    n_sum_y     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e       <= n_e;
        r_cnt     <= n_cnt;
        r_sq_v    <= n_sq_v;
        r_sq_rem  <= n_sq_rem;
        r_root    <= n_root;
        r_dv_q    <= n_dv_q;
        r_dv_rem  <= n_dv_rem;
        r_dv_den  <= n_dv_den;
        r_num_neg <= n_num_neg;
        r_t       <= n_t;
        r_u       <= n_u;
        r_g       <= n_g;
        r_prod    <= n_prod;
        r_axis    <= n_axis;
        r_fx      <= n_fx;
        r_fy      <= n_fy;
    end

    assign o_valid   = r_out_valid;
    assign o_force_x = r_fx;
    assign o_force_y = r_fy;

endmodule
`default_nettype wire
